### hdl/float_pixel_quantize_remosaic_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the float pixel quantizer
// Shared helpers for concurrent checks in the block.
// ----------------------------------------------------------------------------
`ifndef FLOAT_PIXEL_QUANTIZE_REMOSAIC_TOP_DEFINES_SVH
`define FLOAT_PIXEL_QUANTIZE_REMOSAIC_TOP_DEFINES_SVH

// same-cycle implication
`define FPQR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fpqr check failed");

// next-cycle implication
`define FPQR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fpqr check failed");

`endif

### hdl/fpqr_pkg.sv
// ----------------------------------------------------------------------------
// fpqr_pkg
// Types, constants and the Bayer layout table of the float pixel quantizer.
// ----------------------------------------------------------------------------
package fpqr_pkg;

   localparam int unsigned ValueWidth = 32;
   localparam int unsigned CodeWidth  = 16;
   localparam int unsigned ProdWidth  = 40;
   localparam int unsigned AddrWidth  = 3;

   // exponent limits for the nonzero, unsaturated range
   localparam logic [7:0] ExpZeroBelow = 8'd110;
   localparam logic [7:0] ExpSatFrom   = 8'd127;
   localparam logic [7:0] ExpBias150   = 8'd150;
   localparam logic [7:0] ExpNonFinite = 8'hFF;

   localparam logic       ModeLinear = 1'b0;
   localparam logic       ModeCfa    = 1'b1;
   localparam logic [1:0] CountLinear = 2'd3;
   localparam logic [1:0] CountCfa    = 2'd1;

   localparam logic [0:0] RegProjectionMode = 1'd0;
   localparam logic [0:0] RegBayerLayout    = 1'd1;

   localparam logic [1:0] ChanRed   = 2'd0;
   localparam logic [1:0] ChanGreen = 2'd1;
   localparam logic [1:0] ChanBlue  = 2'd2;

   typedef struct packed {
      logic s1;
      logic s2;
   } stage_en_type;

   // channel picked by layout (BGGR, RGGB, GRBG, GBRG) at site row*2+col
   function automatic logic [1:0] layout_channel(input logic [1:0] layout,
                                                 input logic [1:0] site);
      logic [1:0] ch;
      unique case ({layout, site})
         4'h0: ch = ChanBlue;  4'h1: ch = ChanGreen; 4'h2: ch = ChanGreen; 4'h3: ch = ChanRed;
         4'h4: ch = ChanRed;   4'h5: ch = ChanGreen; 4'h6: ch = ChanGreen; 4'h7: ch = ChanBlue;
         4'h8: ch = ChanGreen; 4'h9: ch = ChanRed;   4'hA: ch = ChanBlue;  4'hB: ch = ChanGreen;
         4'hC: ch = ChanGreen; 4'hD: ch = ChanBlue;  4'hE: ch = ChanRed;   4'hF: ch = ChanGreen;
         default: ch = ChanRed;
      endcase
      return ch;
   endfunction

endpackage

### hdl/fpqr_req_if.sv
// ----------------------------------------------------------------------------
// fpqr_req_if
// Pixel input channel: three float channels plus position and tile marker.
// ----------------------------------------------------------------------------
interface fpqr_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] red_value;
   logic [31:0] green_value;
   logic [31:0] blue_value;
   logic        column_parity;
   logic        row_parity;
   logic        end_of_tile;

   modport source (output valid, red_value, green_value, blue_value,
                   column_parity, row_parity, end_of_tile, input ready);
   modport sink   (input valid, red_value, green_value, blue_value,
                   column_parity, row_parity, end_of_tile, output ready);
endinterface

### hdl/fpqr_rsp_if.sv
// ----------------------------------------------------------------------------
// fpqr_rsp_if
// Result channel: up to three 16-bit codes, code count and tile marker.
// ----------------------------------------------------------------------------
interface fpqr_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_first;
   logic [15:0] code_second;
   logic [15:0] code_third;
   logic [1:0]  code_count;
   logic        tile_done;

   modport source (output valid, code_first, code_second, code_third,
                   code_count, tile_done, input ready);
   modport sink   (input valid, code_first, code_second, code_third,
                   code_count, tile_done, output ready);
endinterface

### hdl/fpqr_quant.sv
// ----------------------------------------------------------------------------
// fpqr_quant
// Two-stage float to 16-bit code quantizer for one channel.
// ----------------------------------------------------------------------------
module fpqr_quant
   import fpqr_pkg::*;
(
   input  logic                 clock,
   input  stage_en_type         en,
   input  logic [ValueWidth-1:0] value,
   output logic [CodeWidth-1:0]  code
);

   logic [7:0]           expo;
   logic [23:0]          mant;
   logic                 zero_in, zero_ff;
   logic                 sat_in, sat_ff;
   logic [ProdWidth-1:0] prod_in, prod_ff;
   logic [7:0]           shift_full;
   logic [5:0]           shift_in, shift_ff;
   logic [ProdWidth:0]   sum;
   logic [ProdWidth:0]   shifted;
   logic [CodeWidth-1:0] code_in, code_ff;

   // stage 1: classify, form mantissa * 65535
   always_comb begin
      expo       = value[30:23];
      mant       = {(expo != 8'd0), value[22:0]};
      zero_in    = (expo == ExpNonFinite) || value[31] || (expo < ExpZeroBelow);
      sat_in     = (expo >= ExpSatFrom);
      prod_in    = {mant, 16'd0} - {16'd0, mant};
      shift_full = ExpBias150 - expo;
      shift_in   = shift_full[5:0];
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         zero_ff  <= zero_in;
         sat_ff   <= sat_in;
         prod_ff  <= prod_in;
         shift_ff <= shift_in;
      end
   end

   // stage 2: add half, drop fraction
   always_comb begin
      sum     = {1'b0, prod_ff} + ((ProdWidth+1)'(1) << (shift_ff - 6'd1));
      shifted = sum >> shift_ff;
      priority if (zero_ff) code_in = '0;
      else if (sat_ff)      code_in = '1;
      else                  code_in = shifted[CodeWidth-1:0];
   end

   always_ff @(posedge clock) begin
      if (en.s2) code_ff <= code_in;
   end

   assign code = code_ff;

endmodule

### hdl/float_pixel_quantize_remosaic_top.sv
// ----------------------------------------------------------------------------
// float_pixel_quantize_remosaic_top
// Float RGB pixel to 16-bit codes, linear or Bayer remosaic output.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one pixel per transfer: three IEEE single floats (R, G, B),
//   column/row parity and an end-of-tile marker. rsp_chan returns exactly one
//   result per pixel, in order: three codes in linear mode, or one code picked
//   from the Bayer layout in CFA mode (other codes zero), with a code count.
//   Each result is registered through the three-stage pipeline (decode and
//   product, round and shift, select into the output register); one pixel per
//   cycle is sustained while the receiver is ready.
//   Each stage advances when it is empty or the next one advances, so bubbles
//   collapse and input is taken while a result waits, as long as a stage is free.
//   When the receiver stalls, hold every full stage; nothing is dropped or repeated.
//   The APB port at csr_ sets projection_mode (addr 0) and bayer_layout (addr 4);
//   write it only while the pipeline is empty.
//   Reset (synchronous) empties the pipeline and clears both registers.
// ----------------------------------------------------------------------------
`include "float_pixel_quantize_remosaic_top_defines.svh"

module float_pixel_quantize_remosaic_top
   import fpqr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   fpqr_req_if.sink             req_chan,
   fpqr_rsp_if.source           rsp_chan,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [AddrWidth-1:0] csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);

   // configuration registers
   logic       mode_ff, mode_in;
   logic [1:0] layout_ff, layout_in;
   logic       csr_write;
   logic [0:0] csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[2:2];

   always_comb begin
      mode_in   = mode_ff;
      layout_in = layout_ff;
      if (csr_write) begin
         unique case (csr_index)
            RegProjectionMode: mode_in   = csr_pwdata[0];
            RegBayerLayout:    layout_in = csr_pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= ModeLinear;
         layout_ff <= 2'd0;
      end else begin
         mode_ff   <= mode_in;
         layout_ff <= layout_in;
      end
   end

   always_comb begin
      unique case (csr_index)
         RegProjectionMode: csr_prdata = {31'd0, mode_ff};
         RegBayerLayout:    csr_prdata = {30'd0, layout_ff};
         default:           csr_prdata = '0;
      endcase
   end

   // pipeline control: a stage advances when empty or its successor advances
   logic         v1_ff, v2_ff, v3_ff;
   logic         adv1, adv2, adv3;
   stage_en_type en;

   assign adv3  = !v3_ff || rsp_chan.ready;
   assign adv2  = !v2_ff || adv3;
   assign adv1  = !v1_ff || adv2;
   assign en    = '{s1: adv1, s2: adv2};
   assign req_chan.ready = adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_chan.valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
      end
   end

   // sideband travels with the data: site index and tile marker
   logic [1:0] site1_ff, site2_ff;
   logic       eot1_ff, eot2_ff;

   always_ff @(posedge clock) begin
      if (adv1) begin
         site1_ff <= {req_chan.row_parity, req_chan.column_parity};
         eot1_ff  <= req_chan.end_of_tile;
      end
      if (adv2) begin
         site2_ff <= site1_ff;
         eot2_ff  <= eot1_ff;
      end
   end

   // per-channel quantizers (stages 1 and 2)
   logic [CodeWidth-1:0] red_code, green_code, blue_code;

   fpqr_quant u_quant_red (
      .clock (clock), .en (en), .value (req_chan.red_value), .code (red_code)
   );
   fpqr_quant u_quant_green (
      .clock (clock), .en (en), .value (req_chan.green_value), .code (green_code)
   );
   fpqr_quant u_quant_blue (
      .clock (clock), .en (en), .value (req_chan.blue_value), .code (blue_code)
   );

   // stage 3: pick codes per mode into the output register
   logic [CodeWidth-1:0] first_in, second_in, third_in;
   logic [CodeWidth-1:0] first_ff, second_ff, third_ff;
   logic [1:0]           count_in, count_ff;
   logic                 eot3_ff;
   logic [1:0]           pick;

   always_comb begin
      pick = layout_channel(layout_ff, site2_ff);
      if (mode_ff == ModeCfa) begin
         unique case (pick)
            ChanRed:   first_in = red_code;
            ChanGreen: first_in = green_code;
            ChanBlue:  first_in = blue_code;
            default:   first_in = red_code;
         endcase
         second_in = '0;
         third_in  = '0;
         count_in  = CountCfa;
      end else begin
         first_in  = red_code;
         second_in = green_code;
         third_in  = blue_code;
         count_in  = CountLinear;
      end
   end

   always_ff @(posedge clock) begin
      if (adv3) begin
         first_ff  <= first_in;
         second_ff <= second_in;
         third_ff  <= third_in;
         count_ff  <= count_in;
         eot3_ff   <= eot2_ff;
      end
   end

   assign rsp_chan.valid       = v3_ff;
   assign rsp_chan.code_first  = first_ff;
   assign rsp_chan.code_second = second_ff;
   assign rsp_chan.code_third  = third_ff;
   assign rsp_chan.code_count  = count_ff;
   assign rsp_chan.tile_done   = eot3_ff;

   // checks
   `FPQR_ASSERT_SAME(a_cfa_zero_rest, clock, reset,
      rsp_chan.valid && (rsp_chan.code_count == CountCfa),
      (rsp_chan.code_second == '0) && (rsp_chan.code_third == '0))
   `FPQR_ASSERT_SAME(a_count_legal, clock, reset,
      rsp_chan.valid,
      (rsp_chan.code_count == CountCfa) || (rsp_chan.code_count == CountLinear))
   `FPQR_ASSERT_NEXT(a_input_lands, clock, reset,
      req_chan.valid && req_chan.ready, v1_ff)
   `FPQR_ASSERT_NEXT(a_stage2_holds, clock, reset,
      v2_ff && !adv3, v2_ff)

endmodule

### test/tb_float_pixel_quantize_remosaic_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Float pixel quantizer testbench
// Streams float RGB pixels through the block in linear and CFA modes under
// all Bayer layouts, with bursty input and a stalling receiver, and checks
// every result against an exact integer model of the quantizer.
// ----------------------------------------------------------------------------
module tb_float_pixel_quantize_remosaic_top
   import fpqr_pkg::*;
();

   typedef struct packed {
      logic [15:0] first;
      logic [15:0] second;
      logic [15:0] third;
      logic [1:0]  count;
      logic        tile;
   } code_set_type;

   // channel picked by layout (BGGR, RGGB, GRBG, GBRG) at site row*2+col
   localparam logic [1:0] SiteChannel [4][4] = '{
      '{ChanBlue,  ChanGreen, ChanGreen, ChanRed},
      '{ChanRed,   ChanGreen, ChanGreen, ChanBlue},
      '{ChanGreen, ChanRed,   ChanBlue,  ChanGreen},
      '{ChanGreen, ChanBlue,  ChanRed,   ChanGreen}};

   localparam int unsigned MaxCycles   = 200000;
   localparam int unsigned DrainCycles = 10;

   // Expected codes per accepted pixel, in transfer order.
   class code_scoreboard;
      logic         mode;
      logic [1:0]   layout;
      code_set_type pending_codes[$];
      int unsigned  mismatches;

      function new();
         mode = ModeLinear;
         layout = 2'd0;
         mismatches = 0;
      endfunction

      // Exact round half up of clamp(v)*65535 in integers.
      function logic [15:0] quantize(logic [31:0] v);
         logic [7:0]  e;
         logic [63:0] sum;
         e = v[30:23];
         if (e == ExpNonFinite || v[31] || v[30:0] == 31'd0) return 16'd0;
         if (e >= 8'd127) return 16'hFFFF;
         if (e < 8'd100) return 16'd0;
         sum = {40'd0, 1'b1, v[22:0]} * 64'd131070 + (64'd1 << (150 - e));
         return 16'(sum >> (151 - e));
      endfunction

      function void note_pixel(logic [31:0] r, logic [31:0] g, logic [31:0] b,
                               logic col, logic row, logic eot);
         code_set_type c;
         logic [15:0]  codes [3];
         codes[0] = quantize(r);
         codes[1] = quantize(g);
         codes[2] = quantize(b);
         c.tile = eot;
         if (mode == ModeLinear) begin
            c.first = codes[0];
            c.second = codes[1];
            c.third = codes[2];
            c.count = CountLinear;
         end else begin
            c.first = codes[SiteChannel[layout][{row, col}]];
            c.second = 16'd0;
            c.third = 16'd0;
            c.count = CountCfa;
         end
         pending_codes = {pending_codes, c};
      endfunction

      function void check_result(code_set_type got);
         code_set_type exp_c;
         if (pending_codes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
            return;
         end
         exp_c = pending_codes.pop_front();
         if (got !== exp_c) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"mismatch: expected %h %h %h cnt %0d tile %0b,",
                         " got %h %h %h cnt %0d tile %0b"},
                        exp_c.first, exp_c.second, exp_c.third, exp_c.count, exp_c.tile,
                        got.first, got.second, got.third, got.count, got.tile);
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 csr_psel;
   logic                 csr_penable;
   logic                 csr_pwrite;
   logic [AddrWidth-1:0] csr_paddr;
   logic [31:0]          csr_pwdata;
   logic [31:0]          csr_prdata;
   logic                 csr_pready;
   int unsigned          cycle_count;
   code_scoreboard       sb;

   fpqr_req_if req_bus ();
   fpqr_rsp_if rsp_bus ();

   float_pixel_quantize_remosaic_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Monitor both channels at the rising edge: note accepted pixels, check
   // accepted results. Config never changes while pixels are in flight.
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready)
         sb.note_pixel(req_bus.red_value, req_bus.green_value, req_bus.blue_value,
                       req_bus.column_parity, req_bus.row_parity, req_bus.end_of_tile);
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_result({rsp_bus.code_first, rsp_bus.code_second, rsp_bus.code_third,
                          rsp_bus.code_count, rsp_bus.tile_done});
   end

   // Watchdog: end the run if traffic ever hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= MaxCycles) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Receiver: rotate with the cycle counter among always ready, random stalls,
   // long stalls and rare stalls, so back pressure hits every pipeline phase.
   always @(negedge clock) begin
      case (cycle_count[7:6])
         2'd0: rsp_bus.ready <= 1'b1;
         2'd1: rsp_bus.ready <= $urandom_range(0, 1);
         2'd2: rsp_bus.ready <= ($urandom_range(0, 7) == 0);
         default: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // Present one pixel at the falling edge and hold it until the transfer.
   task automatic send_pixel(logic [31:0] r, logic [31:0] g, logic [31:0] b,
                             logic col, logic row, logic eot);
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.red_value <= r;
      req_bus.green_value <= g;
      req_bus.blue_value <= b;
      req_bus.column_parity <= col;
      req_bus.row_parity <= row;
      req_bus.end_of_tile <= eot;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic hold_off(int unsigned cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
   endtask

   // Two-phase APB write; pready is tied high by the block.
   task automatic csr_write(logic [AddrWidth-1:0] addr, logic [31:0] data);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // Drop valid, drain all pending results, then reprogram both registers.
   task automatic set_mode(logic [31:0] mode_word, logic [31:0] layout_word);
      hold_off(4);
      while (sb.pending_codes.size() != 0) @(posedge clock);
      csr_write({RegProjectionMode, 2'b00}, mode_word);
      csr_write({RegBayerLayout, 2'b00}, layout_word);
      sb.mode = mode_word[0];
      sb.layout = layout_word[1:0];
   endtask

   // Mostly in-range values, plus full random, non-finite, above one, tiny.
   function automatic logic [31:0] random_value();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return {1'b0, 8'($urandom_range(100, 126)), 23'($urandom)};
         6: return $urandom;
         7: return {1'($urandom), ExpNonFinite, 23'($urandom)};
         8: return {1'b0, 8'($urandom_range(127, 254)), 23'($urandom)};
         default: return {1'($urandom), 8'($urandom_range(0, 99)), 23'($urandom)};
      endcase
   endfunction

   task automatic random_burst(int unsigned items);
      int unsigned burst;
      burst = 0;
      repeat (items) begin
         if (burst == 0) begin
            burst = $urandom_range(1, 16);
            if ($urandom_range(0, 2) != 0) hold_off($urandom_range(1, 6));
         end
         burst--;
         send_pixel(random_value(), random_value(), random_value(),
                    1'($urandom), 1'($urandom), 1'($urandom));
      end
   endtask

   logic [31:0] edge_values [12] = '{
      32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'h3F80_0001,
      32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'hFFFF_FFFF,
      32'h0000_0001, 32'h3F00_0000, 32'h7F7F_FFFF, 32'h3780_0000};

   initial begin
      sb = new();
      cycle_count = 0;
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.red_value = '0;
      req_bus.green_value = '0;
      req_bus.blue_value = '0;
      req_bus.column_parity = 1'b0;
      req_bus.row_parity = 1'b0;
      req_bus.end_of_tile = 1'b0;
      rsp_bus.ready = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Linear mode from reset: special values in every channel.
      foreach (edge_values[i])
         send_pixel(edge_values[i], edge_values[(i + 4) % 12], edge_values[(i + 8) % 12],
                    1'(i), 1'(i >> 1), 1'(i == 11));

      // CFA, wide write data keeps only the low bits: all four sites, two layouts.
      set_mode(32'hFFFF_FFFF, 32'hFFFF_FFFC);
      for (int s = 0; s < 8; s++)
         send_pixel(32'h3E80_0000, 32'h3F00_0000, 32'h3F40_0000,
                    1'(s), 1'(s >> 1), 1'(s == 7));
      set_mode(32'd1, 32'd3);
      for (int s = 0; s < 4; s++)
         send_pixel(32'h3E80_0000, 32'h3F00_0000, 32'h3F40_0000, 1'(s), 1'(s >> 1), 1'b0);

      // Random phases across all settings.
      set_mode(32'd0, 32'd0);
      random_burst(50);
      for (int l = 0; l < 4; l++) begin
         set_mode(32'd1, l);
         random_burst(60);
      end
      set_mode(32'd0, 32'd2);
      random_burst(50);
      set_mode(32'd1, 32'd1);
      random_burst(60);
      hold_off(1);

      while (sb.pending_codes.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
